// ----- rtl/psior_pkg.sv -----
// ----------------------------------------------------------------------------
// psior_pkg: shared types and constants
// Error codes, descriptor types and back-end state encoding.
// ----------------------------------------------------------------------------
package psior_pkg;

  localparam int SOURCE_W = 6;
  localparam int SLOT_W   = 6;
  localparam int LEN_W    = 31;
  localparam int REQ_W    = 16;
  localparam int ERR_W    = 2;
  localparam int CFG_W    = 7;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SOURCE   = 2'd2;

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    logic                ordered;
    logic [REQ_W-1:0]    sequence_req;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    length;
    logic                bad_source;
  } desc_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    length;
    logic [ERR_W-1:0]    error;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

// ----- rtl/per_source_in_order_release.sv -----
// ----------------------------------------------------------------------------
// per_source_in_order_release: per-source sequence reorder buffer
// Releases message descriptors in per-source count order.
// ----------------------------------------------------------------------------
// Input words (source, ordered, sequence_req, slot, length) enter a two-word
// queue with valid/ready. The release engine takes one word at a time.
// Unordered and out-of-range words go from LOOKUP straight to EMIT; a held
// word is written to the holding queue in DECIDE, then the engine is idle.
// A matching ordered word waits while the holding queue is scanned one entry
// per cycle for the next count; each hit sends out the previous result and
// starts another scan. A word yields up to QUEUE_DEPTH+1 results; the final
// one carries last. Results sit in an output register and wait while ready
// is low; the engine stalls, the input queue keeps taking words until full.
// Reset clears the input queue, all hold valid bits and the per-source
// written flags (so expected counts read as zero until written), and sets
// active_sources to 64.
// active_sources is at APB address 0.
// ----------------------------------------------------------------------------
module per_source_in_order_release
  import psior_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  parameter int QUEUE_DEPTH = 32,
  parameter int SEQ_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SOURCE_W-1:0] source,
  input  logic                ordered,
  input  logic [REQ_W-1:0]    sequence_req,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [LEN_W-1:0]    length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SOURCE_W-1:0] out_source,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [LEN_W-1:0]    out_length,
  output logic [ERR_W-1:0]    error,
  output logic                last
);

  logic [CFG_W-1:0] active_sources;
  logic    desc_valid, desc_ready;
  desc_t   desc;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, active_sources} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) active_sources <= 7'd64;
    else if (psel && penable && pwrite && paddr == 2'd0) active_sources <= pwdata[6:0];
  end

  psior_front #(.MAX_SOURCES(MAX_SOURCES)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .source(source), .ordered(ordered), .sequence_req(sequence_req),
    .slot(slot), .length(length), .active_sources(active_sources),
    .desc_valid(desc_valid), .desc_ready(desc_ready), .desc(desc)
  );

  psior_back #(.MAX_SOURCES(MAX_SOURCES), .QUEUE_DEPTH(QUEUE_DEPTH),
               .SEQ_BITS(SEQ_BITS)) u_back (
    .clk(clk), .rst(rst), .desc_valid(desc_valid), .desc_ready(desc_ready),
    .desc(desc), .res_valid(out_valid), .res_ready(out_ready), .res(res)
  );

  assign out_source = res.source;
  assign out_slot   = res.slot;
  assign out_length = res.length;
  assign error      = res.error;
  assign last       = res.last;

endmodule

// ----- rtl/psior_front.sv -----
// ----------------------------------------------------------------------------
// psior_front: input stage
// Accepts words, checks the source range and queues descriptors.
// ----------------------------------------------------------------------------
module psior_front
  import psior_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  parameter int FIFO_DEPTH  = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic [SOURCE_W-1:0] source,
  input  logic                ordered,
  input  logic [REQ_W-1:0]    sequence_req,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [LEN_W-1:0]    length,
  input  logic [CFG_W-1:0]    active_sources,
  output logic                desc_valid,
  input  logic                desc_ready,
  output desc_t               desc
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  desc_t         fifo [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;
  logic          bad;
  logic [10:0]   limit;

  always_comb begin
    limit = (11'(active_sources) > 11'(MAX_SOURCES)) ? 11'(MAX_SOURCES) : 11'(active_sources);
    bad   = 11'(source) >= limit;
  end

  assign ready      = count != (PW+1)'(FIFO_DEPTH);
  assign push       = valid && ready;
  assign desc_valid = count != '0;
  assign pop        = desc_valid && desc_ready;
  assign desc       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{source, ordered, sequence_req, slot, length, bad};
    end
  end

endmodule

// ----- rtl/psior_ram.sv -----
// ----------------------------------------------------------------------------
// psior_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psior_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/psior_back.sv -----
// ----------------------------------------------------------------------------
// psior_back: release engine
// Looks up the expected count, holds or releases, and scans the holding
// queue one entry per cycle for the next count of the same source.
// ----------------------------------------------------------------------------
module psior_back
  import psior_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  parameter int QUEUE_DEPTH = 32,
  parameter int SEQ_BITS    = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    desc_valid,
  output logic    desc_ready,
  input  desc_t   desc,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int SW = $clog2(MAX_SOURCES);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = SEQ_BITS;
  localparam int HW = SW + CW + SLOT_W + LEN_W;

  back_state_t state, state_next;
  desc_t       cur;
  result_t     pend;
  logic [SW-1:0] cur_src;
  logic [CW-1:0] exp_cnt;
  logic [CW-1:0] ex_cur;
  logic [MAX_SOURCES-1:0] ex_written;
  logic [QUEUE_DEPTH-1:0] hvalid;
  logic [QW-1:0] scan_idx;
  logic [QW-1:0] chk_idx;
  logic [QW:0]   scan_cnt;

  // expected count RAM
  logic          ex_we;
  logic [SW-1:0] ex_waddr;
  logic [CW-1:0] ex_wdata;
  logic [CW-1:0] ex_rdata;

  // holding queue RAM
  logic          h_we;
  logic [QW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [QW-1:0] h_raddr;
  logic [HW-1:0] h_rdata;
  logic          h_rvalid;

  logic [CW-1:0] req_cnt;
  logic          full;
  logic [QW-1:0] free_idx;

  logic [SW-1:0]     h_src;
  logic [CW-1:0]     h_cnt;
  logic [SLOT_W-1:0] h_slot;
  logic [LEN_W-1:0]  h_len;
  logic              hit;

  assign cur_src = SW'(cur.source);
  assign req_cnt = CW'(cur.sequence_req);
  assign full    = &hvalid;
  // counts never written since reset read as zero
  assign ex_cur  = ex_written[cur_src] ? ex_rdata : '0;

  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH-1; i >= 0; i--) begin
      if (!hvalid[i]) free_idx = QW'(i);
    end
  end

  psior_ram #(.WIDTH(CW), .DEPTH(MAX_SOURCES)) u_exp (
    .clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
    .raddr(cur_src), .rdata(ex_rdata)
  );

  psior_ram #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_hold (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign {h_src, h_cnt, h_slot, h_len} = h_rdata;

  assign hit = h_rvalid && (h_src == cur_src) && (h_cnt == exp_cnt);

  assign desc_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_EMIT);
  assign h_raddr    = scan_idx;

  always_comb begin
    state_next = state;
    ex_we    = 1'b0;
    ex_waddr = cur_src;
    ex_wdata = exp_cnt + 1'b1;
    h_we     = 1'b0;
    h_waddr  = free_idx;
    h_wdata  = {cur_src, req_cnt, cur.slot, cur.length};
    unique case (state)
      ST_IDLE: begin
        if (desc_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (cur.bad_source || !cur.ordered) state_next = ST_EMIT;
        else state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_cnt == ex_cur) begin
          ex_we      = 1'b1;
          ex_wdata   = ex_cur + 1'b1;
          state_next = ST_SCAN;
        end else if (full) begin
          state_next = ST_EMIT;
        end else begin
          h_we       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ex_we      = 1'b1;
          state_next = ST_EMIT;
        end else if (scan_cnt == (QW+1)'(QUEUE_DEPTH)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          if (res.last) state_next = ST_IDLE;
          else state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid     <= '0;
      ex_written <= '0;
    end else begin
      if (h_we) hvalid[free_idx] <= 1'b1;
      if (state == ST_SCAN && hit) hvalid[chk_idx] <= 1'b0;
      if (ex_we) ex_written[ex_waddr] <= 1'b1;
    end
  end

  // a released word waits in pend until the next scan tells whether it is last
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (desc_valid) cur <= desc;
      end
      ST_LOOKUP: begin
        res <= '{cur.source, cur.slot, cur.length,
                 cur.bad_source ? ERR_SOURCE : ERR_OK, 1'b1};
      end
      ST_DECIDE: begin
        exp_cnt  <= ex_cur + 1'b1;
        pend     <= '{cur.source, cur.slot, cur.length, ERR_OK, 1'b0};
        res      <= '{cur.source, cur.slot, cur.length, ERR_OVERFLOW, 1'b1};
        scan_idx <= '0;
        scan_cnt <= '0;
        h_rvalid <= 1'b0;
      end
      ST_SCAN: begin
        h_rvalid <= hvalid[scan_idx];
        chk_idx  <= scan_idx;
        if (scan_idx != QW'(QUEUE_DEPTH-1)) scan_idx <= scan_idx + 1'b1;
        scan_cnt <= scan_cnt + 1'b1;
        if (hit) begin
          exp_cnt <= exp_cnt + 1'b1;
          res     <= '{pend.source, pend.slot, pend.length, ERR_OK, 1'b0};
          pend    <= '{SOURCE_W'(h_src), h_slot, h_len, ERR_OK, 1'b0};
        end else if (scan_cnt == (QW+1)'(QUEUE_DEPTH)) begin
          res     <= '{pend.source, pend.slot, pend.length, ERR_OK, 1'b1};
        end
      end
      ST_EMIT: begin
        if (res_ready && !res.last) begin
          scan_idx <= '0;
          scan_cnt <= '0;
          h_rvalid <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/per_source_in_order_release_tb.sv -----
// ----------------------------------------------------------------------------
// per_source_in_order_release_tb: reorder buffer testbench
// Drives message descriptor words with random gaps and output stalls, keeps a
// per-source count and holding queue model, and checks every released or
// rejected word field by field, in order. Covers in-order release, chained
// drain of held words, duplicate counts, queue overflow and source limits.
// ----------------------------------------------------------------------------
module per_source_in_order_release_tb
  import psior_pkg::*;
();

  localparam int NSRC  = 64;
  localparam int DEPTH = 32;
  localparam int SETTLE = 2 * DEPTH + 40;
  localparam int RING  = 1024;

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite, pready;
  logic [1:0]          paddr;
  logic [31:0]         pwdata, prdata;
  logic                in_valid, in_ready;
  logic [SOURCE_W-1:0] source;
  logic                ordered;
  logic [REQ_W-1:0]    sequence_req;
  logic [SLOT_W-1:0]   slot;
  logic [LEN_W-1:0]    length;
  logic                out_valid, out_ready;
  logic [SOURCE_W-1:0] out_source;
  logic [SLOT_W-1:0]   out_slot;
  logic [LEN_W-1:0]    out_length;
  logic [ERR_W-1:0]    error;
  logic                last;

  per_source_in_order_release uut (.*);

  // model state
  logic [REQ_W-1:0]    next_count [NSRC];
  logic                held_valid [DEPTH];
  logic [SOURCE_W-1:0] held_src   [DEPTH];
  logic [REQ_W-1:0]    held_seq   [DEPTH];
  logic [SLOT_W-1:0]   held_slot  [DEPTH];
  logic [LEN_W-1:0]    held_len   [DEPTH];
  int unsigned         cfg_sources;
  result_t             exp_ring [RING];
  int unsigned         ring_wr;
  int unsigned         ring_rd;

  int  errors;
  int  words_sent;
  int  results_seen;
  bit  quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 10000000);
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (held_valid[i]) n++;
    return n;
  endfunction

  function automatic result_t mk_result(logic [SOURCE_W-1:0] s, logic [SLOT_W-1:0] sl,
                                        logic [LEN_W-1:0] l, logic [ERR_W-1:0] e);
    result_t r;
    r.source = s;
    r.slot   = sl;
    r.length = l;
    r.error  = e;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void reorder_predict(logic [SOURCE_W-1:0] s, logic o,
                                          logic [REQ_W-1:0] q, logic [SLOT_W-1:0] sl,
                                          logic [LEN_W-1:0] l);
    result_t     outs [DEPTH+1];
    int          n_out;
    int unsigned lim;
    int          free_idx, hit;
    n_out = 0;
    lim = (cfg_sources > NSRC) ? NSRC : cfg_sources;
    if (s >= lim) begin
      outs[n_out] = mk_result(s, sl, l, ERR_SOURCE);
      n_out++;
    end else if (!o) begin
      outs[n_out] = mk_result(s, sl, l, ERR_OK);
      n_out++;
    end else if (q != next_count[s]) begin
      free_idx = -1;
      for (int i = DEPTH - 1; i >= 0; i--) if (!held_valid[i]) free_idx = i;
      if (free_idx < 0) begin
        outs[n_out] = mk_result(s, sl, l, ERR_OVERFLOW);
        n_out++;
      end else begin
        held_valid[free_idx] = 1'b1;
        held_src[free_idx]   = s;
        held_seq[free_idx]   = q;
        held_slot[free_idx]  = sl;
        held_len[free_idx]   = l;
      end
    end else begin
      outs[n_out] = mk_result(s, sl, l, ERR_OK);
      n_out++;
      next_count[s] = next_count[s] + 1'b1;
      do begin
        hit = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
          if (held_valid[i] && held_src[i] == s && held_seq[i] == next_count[s]) hit = i;
        if (hit >= 0) begin
          outs[n_out] = mk_result(s, held_slot[hit], held_len[hit], ERR_OK);
          n_out++;
          held_valid[hit] = 1'b0;
          next_count[s] = next_count[s] + 1'b1;
        end
      end while (hit >= 0);
    end
    if (n_out > 0) begin
      outs[n_out - 1].last = 1'b1;
      for (int i = 0; i < n_out; i++) begin
        exp_ring[ring_wr % RING] = outs[i];
        ring_wr++;
      end
    end
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic send_word(input logic [SOURCE_W-1:0] s, input logic o,
                           input logic [REQ_W-1:0] q, input logic [SLOT_W-1:0] sl,
                           input logic [LEN_W-1:0] l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    source       <= s;
    ordered      <= o;
    sequence_req <= q;
    slot         <= sl;
    length       <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reorder_predict(s, o, q, sl, l);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sources(input int unsigned v);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 2'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_sources = v & 32'h7F;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if (rd[CFG_W-1:0] != cfg_sources[CFG_W-1:0])
      report($sformatf("active_sources read %0d, wrote %0d", rd[CFG_W-1:0], cfg_sources));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      result_t e;
      results_seen++;
      if (ring_wr == ring_rd) begin
        report($sformatf("unexpected word src=%0d slot=%0d", out_source, out_slot));
      end else begin
        e = exp_ring[ring_rd % RING];
        ring_rd++;
        if (out_source !== e.source)
          report($sformatf("out_source %0d, want %0d", out_source, e.source));
        if (out_slot !== e.slot)
          report($sformatf("out_slot %0d, want %0d", out_slot, e.slot));
        if (out_length !== e.length)
          report($sformatf("out_length %0h, want %0h", out_length, e.length));
        if (error !== e.error)
          report($sformatf("error %0d, want %0d (src %0d)", error, e.error, e.source));
        if (last !== e.last)
          report($sformatf("last %0b, want %0b (src %0d)", last, e.last, e.source));
      end
    end
  end

  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic test_overflow();
    logic [REQ_W-1:0] e;
    int k;
    e = next_count[5];
    k = 1;
    while (held_count() < DEPTH) begin
      send_word(6'd5, 1'b1, REQ_W'(e + k), k[SLOT_W-1:0], LEN_W'($urandom));
      k++;
    end
    send_word(6'd5, 1'b1, e + 16'd40, 6'd33, 31'h7FFF_FFFF);
    send_word(6'd5, 1'b1, e, 6'd0, 31'd0);
    drain();
  endtask

  task automatic test_basic();
    send_word(6'd0, 1'b0, 16'hFFFF, 6'd32, 31'h7FFF_FFFF);
    send_word(6'd0, 1'b1, next_count[0], 6'd0, 31'd0);
    send_word(6'd1, 1'b1, next_count[1] + 16'd2, 6'd1, 31'd10);
    send_word(6'd1, 1'b1, next_count[1] + 16'd1, 6'd2, 31'd11);
    send_word(6'd1, 1'b1, next_count[1], 6'd3, 31'd12);
    // duplicate counts: one goes out, the other waits for a wrap
    send_word(6'd2, 1'b1, next_count[2] + 16'd1, 6'd4, 31'd1);
    send_word(6'd2, 1'b1, next_count[2] + 16'd1, 6'd5, 31'd2);
    send_word(6'd2, 1'b1, next_count[2], 6'd6, 31'd3);
    send_word(6'd63, 1'b0, 16'h0000, 6'd31, 31'h5555_5555);
    send_word(6'd63, 1'b1, next_count[63], 6'd32, 31'h2AAA_AAAA);
    drain();
  endtask

  task automatic test_sources_limit();
    int unsigned vals [5] = '{1, 0, 127, 33, 64};
    foreach (vals[v]) begin
      set_sources(vals[v]);
      repeat (6) begin
        logic [SOURCE_W-1:0] s;
        s = SOURCE_W'($urandom_range(0, 63));
        send_word(s, 1'($urandom_range(0, 1)), next_count[s],
                  SLOT_W'($urandom_range(0, 32)), LEN_W'($urandom));
      end
      send_word(6'd63, 1'b0, 16'h1234, 6'd7, 31'd99);
      drain();
    end
  endtask

  task automatic test_random(input int unsigned words);
    logic [REQ_W-1:0]    seqs [8];
    logic [REQ_W-1:0]    t;
    logic [SOURCE_W-1:0] s;
    int sent, k, j, r;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(0, 99);
      s = SOURCE_W'($urandom_range(0, 63));
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      if ($urandom_range(0, 29) == 0) drain();
      if (r < 80) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) seqs[i] = REQ_W'(next_count[s] + i);
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = seqs[i]; seqs[i] = seqs[j]; seqs[j] = t;
        end
        for (int i = 0; i < k; i++)
          send_word(s, 1'b1, seqs[i], SLOT_W'($urandom_range(0, 32)), LEN_W'($urandom));
        sent += k;
      end else if (r < 96) begin
        send_word(s, 1'b0, REQ_W'($urandom), SLOT_W'($urandom_range(0, 32)),
                  LEN_W'($urandom));
        sent++;
      end else begin
        send_word(s, 1'b1, REQ_W'($urandom), SLOT_W'($urandom_range(0, 32)),
                  LEN_W'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; source = '0; ordered = 1'b0; sequence_req = '0;
    slot = '0; length = '0;
    errors = 0; words_sent = 0; results_seen = 0; quiet = 1'b0;
    ring_wr = 0; ring_rd = 0;
    cfg_sources = 64;
    for (int i = 0; i < NSRC; i++) next_count[i] = '0;
    for (int i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_overflow();
    test_basic();
    test_sources_limit();
    test_random(200);
    set_sources(48);
    test_random(120);
    set_sources(64);
    test_random(110);
    $display("sent %0d words, checked %0d results: overflow, chained drain, duplicates,",
             words_sent, results_seen);
    $display("source limits 0/1/33/64/127 and random ordered bursts under stalls");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- per_source_in_order_release.f -----
rtl/psior_pkg.sv
rtl/psior_front.sv
rtl/psior_ram.sv
rtl/psior_back.sv
rtl/per_source_in_order_release.sv
sim/per_source_in_order_release_tb.sv
